FILE: hw/rtl/icdf_pkg.sv
// Shared types and constants for the inverse-CDF table sampler.
// Holds table geometry, fixed-point widths, item structs and the controller-to-datapath command.
// No dependencies; every other file refers to it by scoped names.
package icdf_pkg;

	// Table geometry (entry count is a power of two, so the final scaling is a shift)
	localparam int unsigned TABLE_ENTRIES = 1024;
	localparam int unsigned FRAC_BITS     = 16;
	localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int unsigned PROBES        = IDX_W;

	// Field widths of the item structs
	localparam int unsigned OP_W    = 1;
	localparam int unsigned BIN_W   = 10;
	localparam int unsigned PROB_W  = 32;
	localparam int unsigned SCALE_W = 32;
	localparam int unsigned VEL_W   = 32;

	// Fraction divide: numerator is (sample - lower) with FRAC_BITS zeros appended
	localparam int unsigned DIV_STEPS = PROB_W + FRAC_BITS;
	localparam int unsigned NUM_W     = DIV_STEPS;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// Position and scaling product, multiply split into two partial products
	localparam int unsigned POS_W  = NUM_W + 1;
	localparam int unsigned LO_W   = (POS_W + 1) / 2;
	localparam int unsigned HI_W   = POS_W - LO_W;
	localparam int unsigned PROD_W = SCALE_W + POS_W;
	localparam int unsigned SHIFT  = IDX_W + FRAC_BITS;

	localparam logic [IDX_W-1:0] TOP_STEP = {1'b1, {(IDX_W-1){1'b0}}};
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] BASE_MAX = IDX_W'(TABLE_ENTRIES - 2);

	localparam logic [SCALE_W-1:0] VSCALE_RESET = SCALE_W'(65536);

	// Item operation codes
	localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BIN_W-1:0]  entry_index;
		logic [PROB_W-1:0] entry_value;
		logic [PROB_W-1:0] uniform_sample;
	} in_item_t;

	typedef struct packed {
		logic [VEL_W-1:0] velocity;
		logic [BIN_W-1:0] bin_found;
		logic             extrapolated;
		logic             flat_bin;
		logic             saturated;
	} result_t;

	// Table read address source
	typedef enum logic [1:0] {
		RA_FIRST,
		RA_CAND,
		RA_BASE,
		RA_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic    wr_en;
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    chk_below;
		logic    probe;
		logic    fix;
		logic    lat_lower;
		logic    div_init;
		logic    div_step;
		logic    pos_calc;
		logic    mul_lo;
		logic    mul_hi;
		logic    mul_sum;
		logic    emit;
	} dp_cmd_t;

endpackage

FILE: hw/rtl/icdf_ctrl.sv
// Sequencer for the inverse-CDF table sampler.
// Walks one query through read, bisection, divide and scaling; drives icdf_pkg::dp_cmd_t.
// Depends on icdf_pkg.
module icdf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [icdf_pkg::OP_W-1:0]     op,
	output logic                          busy,
	output icdf_pkg::dp_cmd_t             cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_CHK_FIRST,
		ST_PROBE_RD,
		ST_PROBE_CMP,
		ST_FIX,
		ST_RD_LO,
		ST_RD_HI,
		ST_DIV_SETUP,
		ST_DIV,
		ST_POS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t                         state_q;
	logic [icdf_pkg::CNT_W-1:0]     cnt_q;
	logic                           busy_q;

	// State, step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && (op == icdf_pkg::OP_QUERY)) begin
						state_q <= ST_RD_FIRST;
						busy_q  <= 1'b1;
					end
				end
				ST_RD_FIRST:  state_q <= ST_CHK_FIRST;
				ST_CHK_FIRST: begin
					state_q <= ST_PROBE_RD;
					cnt_q   <= icdf_pkg::CNT_W'(icdf_pkg::PROBES - 1);
				end
				ST_PROBE_RD:  state_q <= ST_PROBE_CMP;
				ST_PROBE_CMP: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_PROBE_RD;
					end
				end
				ST_FIX:       state_q <= ST_RD_LO;
				ST_RD_LO:     state_q <= ST_RD_HI;
				ST_RD_HI:     state_q <= ST_DIV_SETUP;
				ST_DIV_SETUP: begin
					state_q <= ST_DIV;
					cnt_q   <= icdf_pkg::CNT_W'(icdf_pkg::DIV_STEPS - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_POS;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_POS:    state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_OUT;
				ST_OUT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	// Decode datapath commands from the state
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = icdf_pkg::RA_FIRST;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_en = start && (op == icdf_pkg::OP_WRITE);
				cmd.load  = start && (op == icdf_pkg::OP_QUERY);
			end
			ST_RD_FIRST: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = icdf_pkg::RA_FIRST;
			end
			ST_CHK_FIRST: cmd.chk_below = 1'b1;
			ST_PROBE_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = icdf_pkg::RA_CAND;
			end
			ST_PROBE_CMP: cmd.probe = 1'b1;
			ST_FIX:       cmd.fix   = 1'b1;
			ST_RD_LO: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = icdf_pkg::RA_BASE;
			end
			ST_RD_HI: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = icdf_pkg::RA_NEXT;
				cmd.lat_lower = 1'b1;
			end
			ST_DIV_SETUP: cmd.div_init = 1'b1;
			ST_DIV:       cmd.div_step = 1'b1;
			ST_POS:       cmd.pos_calc = 1'b1;
			ST_MUL_LO:    cmd.mul_lo   = 1'b1;
			ST_MUL_HI:    cmd.mul_hi   = 1'b1;
			ST_SUM:       cmd.mul_sum  = 1'b1;
			ST_OUT:       cmd.emit     = 1'b1;
			default:      cmd.emit     = 1'b0;
		endcase
	end

endmodule

FILE: hw/rtl/icdf_dpath.sv
// Datapath of the inverse-CDF table sampler: table memory, bisection registers,
// restoring fraction divider, split scaling multiplier and result register.
// Depends on icdf_pkg; steered by icdf_ctrl through icdf_pkg::dp_cmd_t.
module icdf_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  icdf_pkg::dp_cmd_t                 cmd,
	input  icdf_pkg::in_item_t                in_item,
	input  logic [icdf_pkg::SCALE_W-1:0]      vscale,
	output icdf_pkg::result_t                 result,
	output logic                              done
);

	logic [icdf_pkg::PROB_W-1:0] mem [icdf_pkg::TABLE_ENTRIES];
	logic [icdf_pkg::PROB_W-1:0] rdata_q;
	logic [icdf_pkg::IDX_W-1:0]  rd_addr;
	logic                        wr_ok;

	logic [icdf_pkg::PROB_W-1:0] sample_q;
	logic                        below_q;
	logic [icdf_pkg::IDX_W-1:0]  pos_q;
	logic [icdf_pkg::PROB_W-1:0] posval_q;
	logic [icdf_pkg::IDX_W-1:0]  step_q;
	logic [icdf_pkg::IDX_W-1:0]  base_q;
	logic                        extra_q;
	logic [icdf_pkg::PROB_W-1:0] lower_q;
	logic                        flat_q;
	logic                        zero_q;

	logic [icdf_pkg::PROB_W-1:0] rem_q;
	logic [icdf_pkg::NUM_W-1:0]  num_q;
	logic [icdf_pkg::PROB_W-1:0] den_q;

	logic [icdf_pkg::POS_W-1:0]              posfx_q;
	logic [icdf_pkg::SCALE_W+icdf_pkg::LO_W-1:0] acc_q;
	logic [icdf_pkg::SCALE_W+icdf_pkg::HI_W-1:0] phi_q;
	logic [icdf_pkg::PROD_W-1:0]             prod_q;

	icdf_pkg::result_t result_q;
	logic              done_q;

	logic [icdf_pkg::IDX_W:0]    cand_ext;
	logic [icdf_pkg::IDX_W-1:0]  cand;
	logic                        cand_ok;
	logic [icdf_pkg::IDX_W-1:0]  pos_eff;
	logic [icdf_pkg::PROB_W:0]   rem_sh;
	logic [icdf_pkg::PROB_W:0]   rem_diff;
	logic                        rem_ge;
	logic [icdf_pkg::NUM_W-1:0]  frac;
	logic                        sat;

	// Next bisection candidate, dropped when past the end of the table
	assign cand_ext = {1'b0, pos_q} + {1'b0, step_q};
	assign cand     = cand_ext[icdf_pkg::IDX_W-1:0];
	assign cand_ok  = 32'(cand_ext) < icdf_pkg::TABLE_ENTRIES;
	assign pos_eff  = below_q ? '0 : pos_q;
	assign wr_ok    = 32'(in_item.entry_index) < icdf_pkg::TABLE_ENTRIES;

	// Select the table read address
	always_comb begin
		case (cmd.rd_sel)
			icdf_pkg::RA_FIRST: rd_addr = '0;
			icdf_pkg::RA_CAND:  rd_addr = cand;
			icdf_pkg::RA_BASE:  rd_addr = base_q;
			icdf_pkg::RA_NEXT:  rd_addr = base_q + 1'b1;
			default:            rd_addr = '0;
		endcase
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[icdf_pkg::IDX_W'(in_item.entry_index)] <= in_item.entry_value;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// One restoring divide step
	assign rem_sh   = {rem_q, num_q[icdf_pkg::NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign rem_ge   = rem_sh >= {1'b0, den_q};
	assign frac     = zero_q ? '0 : num_q;

	// Saturate the scaled position
	assign sat = |prod_q[icdf_pkg::PROD_W-1:icdf_pkg::SHIFT+icdf_pkg::VEL_W];

	// Query payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_item.uniform_sample;
			pos_q    <= '0;
			posval_q <= '0;
			step_q   <= icdf_pkg::TOP_STEP;
		end
		if (cmd.chk_below) begin
			below_q <= rdata_q > sample_q;
		end
		// Advance the bisection by one probe
		if (cmd.probe) begin
			if (cand_ok && (rdata_q <= sample_q)) begin
				pos_q    <= cand;
				posval_q <= rdata_q;
			end
			step_q <= step_q >> 1;
		end
		// Clamp to bin zero below the table, to the last bin at its top
		if (cmd.fix) begin
			pos_q   <= pos_eff;
			base_q  <= (pos_eff >= icdf_pkg::LAST_IDX) ? icdf_pkg::BASE_MAX : pos_eff;
			extra_q <= (pos_eff == icdf_pkg::LAST_IDX) && (sample_q > posval_q);
		end
		if (cmd.lat_lower) begin
			lower_q <= rdata_q;
		end
		// Load the divider; flat bins and samples under the bin get fraction zero
		if (cmd.div_init) begin
			flat_q <= rdata_q <= lower_q;
			zero_q <= (rdata_q <= lower_q) || below_q || (sample_q < lower_q);
			num_q  <= {sample_q - lower_q, {icdf_pkg::FRAC_BITS{1'b0}}};
			den_q  <= rdata_q - lower_q;
			rem_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[icdf_pkg::PROB_W-1:0] : rem_sh[icdf_pkg::PROB_W-1:0];
			num_q <= {num_q[icdf_pkg::NUM_W-2:0], rem_ge};
		end
		if (cmd.pos_calc) begin
			posfx_q <= icdf_pkg::POS_W'({base_q, {icdf_pkg::FRAC_BITS{1'b0}}})
				+ icdf_pkg::POS_W'(frac);
		end
		// Two partial products, then their aligned sum
		if (cmd.mul_lo) begin
			acc_q <= (icdf_pkg::SCALE_W+icdf_pkg::LO_W)'(vscale)
				* (icdf_pkg::SCALE_W+icdf_pkg::LO_W)'(posfx_q[icdf_pkg::LO_W-1:0]);
		end
		if (cmd.mul_hi) begin
			phi_q <= (icdf_pkg::SCALE_W+icdf_pkg::HI_W)'(vscale)
				* (icdf_pkg::SCALE_W+icdf_pkg::HI_W)'(posfx_q[icdf_pkg::POS_W-1:icdf_pkg::LO_W]);
		end
		if (cmd.mul_sum) begin
			prod_q <= icdf_pkg::PROD_W'(acc_q) + (icdf_pkg::PROD_W'(phi_q) << icdf_pkg::LO_W);
		end
		if (cmd.emit) begin
			result_q.velocity     <= sat ? '1
				: prod_q[icdf_pkg::SHIFT+icdf_pkg::VEL_W-1:icdf_pkg::SHIFT];
			result_q.bin_found    <= icdf_pkg::BIN_W'(pos_q);
			result_q.extrapolated <= extra_q;
			result_q.flat_bin     <= flat_q;
			result_q.saturated    <= sat;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

FILE: hw/rtl/inverse_cdf_table_sampler_top.sv
// Inverse-CDF table sampler.
//
// Input channel: an item is accepted at a rising edge with start high and busy low.
// A write item (op write) stores entry_value at entry_index of the 1024-entry table; it
// produces no result and the next item may follow in the very next cycle.
// A query item (op query) looks up uniform_sample in the table: ten bisection probes of
// the table, two reads for the chosen bin, a 48-step restoring divide for the fraction,
// then a two-part 32 x 49 multiply. busy is raised when a query is accepted and held
// until the result is emitted; done pulses for one cycle with the result in the cycle
// in which busy drops. The query time is set by the one-bit-per-cycle divider and the
// single read port of the table memory (a read state and a compare state per probe).
// Result channel: result is valid only while done is high; the receiver cannot stall it,
// so each result must be taken in that cycle.
// Configuration: APB port, register 0 (velocity_scale, Q16.16) at address 0; write it
// only while busy is low. Reset clears the controller and sets velocity_scale to 1.0;
// table contents are undefined until written, so every entry a query touches must be
// written first.
module inverse_cdf_table_sampler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  icdf_pkg::in_item_t              in_item,
	output logic                            busy,
	output logic                            done,
	output icdf_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam logic REG_VSCALE = 1'b0;

	logic [icdf_pkg::SCALE_W-1:0] vscale_q;
	icdf_pkg::dp_cmd_t            cmd;
	logic                         cfg_wr;

	// Register file: one register, word index in paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vscale_q <= icdf_pkg::VSCALE_RESET;
		end else if (cfg_wr && (paddr[2] == REG_VSCALE)) begin
			vscale_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_VSCALE) ? vscale_q : '0;

	icdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (in_item.op),
		.busy   (busy),
		.cmd    (cmd)
	);

	icdf_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_item),
		.vscale  (vscale_q),
		.result  (result),
		.done    (done)
	);

	// A result transfer never overlaps a query in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done asserted while busy");

	// An accepted query starts the sequence
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (in_item.op == icdf_pkg::OP_QUERY)) |=> busy)
		else $error("query accepted but busy not raised");

	// Nothing accepted from idle yields a result in the next cycle
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe right after acceptance");

	// Every completed query delivers exactly one result as busy drops
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query finished without a result");

endmodule
